// File: rtl/i2cs_pkg.sv
package i2cs_pkg;

    // register store geometry
    localparam int STORE_DEPTH = 256;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // slave address after reset
    localparam logic [6:0] ADDR_RESET = 7'h70;

    // bit position codes inside one byte (values of the bit counter)
    localparam logic [3:0] CNT_ACK  = 4'd8;  // value at which the byte is handled, after its data bits
    localparam logic [3:0] CNT_DONE = 4'd9;  // acknowledge clock in progress

    // classified item handed from front to back
    typedef struct packed {
        logic       sda_low;
        logic       bus_active;
        logic       wrote;
        logic [7:0] write_index;
        logic [7:0] write_byte;
        logic [7:0] peek_address;
    } t_cmd;

endpackage

// File: rtl/i2cs_front.sv
module i2cs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [6:0]        i_cfg_wdata,
    input  logic              i_accept,
    input  logic              i_owner_write,
    input  logic              i_scl_level,
    input  logic              i_sda_level,
    input  logic              i_scl_driven,
    input  logic              i_sda_driven,
    input  logic [7:0]        i_peek_address,
    output i2cs_pkg::t_cmd    o_cmd
);

    // protocol state
    logic [6:0] r_dev_addr;
    logic       r_pclk, r_pdat, r_open, r_addr_seen, r_matched, r_rd_req, r_ptr_seen, r_ack;
    logic [3:0] r_cnt;
    logic [7:0] r_shift, r_ptr;

    logic       n_pclk, n_pdat, n_open, n_addr_seen, n_matched, n_rd_req, n_ptr_seen, n_ack;
    logic [3:0] n_cnt;
    logic [7:0] n_shift, n_ptr;
    logic       c_wrote;
    logic [7:0] c_widx, c_wbyte;
    logic       c_scl, c_sda;

    // next state for one item
    always_comb begin
        n_open      = r_open;
        n_addr_seen = r_addr_seen;
        n_matched   = r_matched;
        n_rd_req    = r_rd_req;
        n_ptr_seen  = r_ptr_seen;
        n_ack       = r_ack;
        n_cnt       = r_cnt;
        n_shift     = r_shift;
        n_ptr       = r_ptr;
        c_wrote     = 1'b0;
        c_widx      = 8'd0;
        c_wbyte     = 8'd0;
        c_scl       = i_owner_write ? i_scl_level : r_pclk;
        c_sda       = i_owner_write ? i_sda_level : r_pdat;
        n_pclk      = c_scl;
        n_pdat      = c_sda;

        if (i_scl_driven) begin
            if (r_pclk && c_scl) begin
                // SDA change with SCL high: start or stop
                if (i_sda_driven) begin
                    if (r_pdat && !c_sda) begin
                        n_open      = 1'b1;
                        n_ack       = 1'b0;
                        n_cnt       = 4'd0;
                        n_addr_seen = 1'b0;
                        n_matched   = 1'b0;
                        n_rd_req    = 1'b0;
                        n_ptr_seen  = 1'b0;
                    end else if (!r_pdat && c_sda) begin
                        n_open = 1'b0;
                        n_cnt  = 4'd0;
                    end
                end
            end else if (!r_pclk && c_scl) begin
                // SCL rising edge inside a live transfer
                if (r_open && (!r_addr_seen || (r_matched && !r_rd_req))) begin
                    if (n_cnt >= i2cs_pkg::CNT_DONE) begin
                        n_ack   = 1'b0;
                        n_shift = 8'd0;
                        n_cnt   = 4'd0;
                    end
                    if (n_cnt < i2cs_pkg::CNT_ACK) begin
                        n_shift = {n_shift[6:0], c_sda};
                    end
                    if (n_cnt == i2cs_pkg::CNT_ACK) begin
                        n_ack = 1'b1;
                        if (!r_addr_seen) begin
                            n_addr_seen = 1'b1;
                            n_matched   = (n_shift[7:1] == r_dev_addr);
                            n_rd_req    = n_shift[0];
                            if ((n_shift[7:1] != r_dev_addr) || n_shift[0]) begin
                                n_ack = 1'b0;
                            end
                        end else if (!r_ptr_seen) begin
                            n_ptr_seen = 1'b1;
                            n_ptr      = n_shift;
                        end else begin
                            c_wrote = 1'b1;
                            c_widx  = r_ptr;
                            c_wbyte = n_shift;
                            n_ptr   = r_ptr + 8'd1;
                        end
                    end
                    n_cnt = n_cnt + 4'd1;
                end
            end
        end
    end

    // classified item
    always_comb begin
        o_cmd.sda_low      = (n_cnt == i2cs_pkg::CNT_DONE) && n_ack;
        o_cmd.bus_active   = n_open;
        o_cmd.wrote        = c_wrote;
        o_cmd.write_index  = c_widx;
        o_cmd.write_byte   = c_wbyte;
        o_cmd.peek_address = i_peek_address;
    end

    // address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= i2cs_pkg::ADDR_RESET;
        end else if (i_cfg_we) begin
            r_dev_addr <= i_cfg_wdata;
        end
    end

    // state update on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pclk      <= 1'b0;
            r_pdat      <= 1'b0;
            r_open      <= 1'b0;
            r_addr_seen <= 1'b0;
            r_matched   <= 1'b0;
            r_rd_req    <= 1'b0;
            r_ptr_seen  <= 1'b0;
            r_ack       <= 1'b0;
            r_cnt       <= 4'd0;
            r_shift     <= 8'd0;
            r_ptr       <= 8'd0;
        end else if (i_accept) begin
            r_pclk      <= n_pclk;
            r_pdat      <= n_pdat;
            r_open      <= n_open;
            r_addr_seen <= n_addr_seen;
            r_matched   <= n_matched;
            r_rd_req    <= n_rd_req;
            r_ptr_seen  <= n_ptr_seen;
            r_ack       <= n_ack;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_ptr       <= n_ptr;
        end
    end

endmodule

// File: rtl/i2cs_queue.sv
module i2cs_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  i2cs_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output i2cs_pkg::t_cmd    o_cmd
);

    // two-entry queue
    i2cs_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr, r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// File: rtl/i2cs_back.sv
module i2cs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  i2cs_pkg::t_cmd    i_cmd,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [26:0]       o_result
);

    localparam int IW = i2cs_pkg::IDX_W;

    // register store with per-entry valid bits (unwritten reads as zero)
    logic [7:0]                       r_mem [i2cs_pkg::STORE_DEPTH];
    logic [i2cs_pkg::STORE_DEPTH-1:0] r_vld;

    logic           r_out_valid;
    i2cs_pkg::t_cmd r_cmd;
    logic [7:0]     r_rd_data;
    logic           r_fwd, r_hit;
    logic [7:0]     c_peek;
    logic [IW-1:0]  c_widx, c_pidx;

    assign c_widx  = i_cmd.write_index[IW-1:0];
    assign c_pidx  = i_cmd.peek_address[IW-1:0];
    assign o_pop   = i_valid && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;

    // memory: write and read-first access on pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_cmd.wrote) begin
                r_mem[c_widx] <= i_cmd.write_byte;
            end
            r_rd_data <= r_mem[c_pidx];
            r_cmd     <= i_cmd;
            r_fwd     <= i_cmd.wrote && (c_widx == c_pidx);
            r_hit     <= r_vld[c_pidx];
        end
    end

    // valid bits and output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && i_cmd.wrote) begin
                r_vld[c_widx] <= 1'b1;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // same-item write is seen by the peek
    assign c_peek = r_fwd ? r_cmd.write_byte : (r_hit ? r_rd_data : 8'd0);

    assign o_result = {c_peek, r_cmd.write_byte, r_cmd.write_index,
                       r_cmd.wrote, r_cmd.bus_active, r_cmd.sda_low};

endmodule

// File: rtl/bitbang_i2c_register_slave.sv
// Write-only I2C register slave driven by software pin writes.
//
// Input stream (s_*): one item per write of the SCL/SDA pin levels and
// directions, plus a store index to inspect. owner_write rides in s_tuser.
// Output stream (m_*): exactly one result item per input item, in order:
// acknowledge drive, bus activity, the data byte stored (if any) and the
// store content at the inspected index after that item.
// Configuration: i_cfg_we with i_cfg_wdata loads the 7-bit slave address
// (0x70 after reset); write it only while the block is idle.
//
// Path: each accepted item is classified by the front into a two-entry queue,
// then popped into the register store access, whose read data is registered
// with the item and shown on m_tvalid/m_tdata.
// Throughput: one item per cycle sustained while m_tready is high; the protocol state
// updates once per item and the store takes one write and one read per cycle.
//
// Reset (i_rst_n low, synchronous): protocol state, queue and output are
// cleared, the address returns to 0x70 and all 256 store bytes read zero.
// When m_tready is low the result holds, the queue fills, and s_tready
// drops once the queue is full; nothing is lost or repeated.
module bitbang_i2c_register_slave (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // scl_level, sda_level, scl_driven, sda_driven,
                                  // peek_address[7:0], zero fill
    input  logic        s_tuser,  // owner_write
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata   // sda_pulled_low, bus_active, wrote, write_index[7:0],
                                  // write_byte[7:0], peek_value[7:0], zero fill
);

    logic           c_accept, c_full, c_qvalid, c_pop;
    i2cs_pkg::t_cmd c_cmd_in, c_cmd_out;
    logic [26:0]    c_result;

    assign s_tready = !c_full;
    assign c_accept = s_tvalid && !c_full;

    // front: pin edges, start/stop and byte handling
    i2cs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_accept       (c_accept),
        .i_owner_write  (s_tuser),
        .i_scl_level    (s_tdata[0]),
        .i_sda_level    (s_tdata[1]),
        .i_scl_driven   (s_tdata[2]),
        .i_sda_driven   (s_tdata[3]),
        .i_peek_address (s_tdata[11:4]),
        .o_cmd          (c_cmd_in)
    );

    // queue between front and back
    i2cs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_accept),
        .i_cmd   (c_cmd_in),
        .o_full  (c_full),
        .i_pop   (c_pop),
        .o_valid (c_qvalid),
        .o_cmd   (c_cmd_out)
    );

    // back: register store and output register
    i2cs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (c_qvalid),
        .i_cmd    (c_cmd_out),
        .o_pop    (c_pop),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_result (c_result)
    );

    assign m_tdata = {5'd0, c_result};

endmodule

// File: rtl/i2cs_checker.sv
module i2cs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no store: index and byte are zero
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[18:3] == 16'd0)
        else $error("write fields set without a store");

    // a store always comes with acknowledge inside an open transfer
    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[0] && m_tdata[1])
        else $error("store without acknowledge");

    // acknowledge only while the bus is active
    a_ack_bus: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[1])
        else $error("acknowledge outside a transfer");

endmodule

bind bitbang_i2c_register_slave i2cs_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/bitbang_i2c_checker.sv
module bitbang_i2c_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,   // scl_level, sda_level, scl_driven, sda_driven,
                                     // peek_address[7:0], zero fill
    input  logic        i_s_tuser,   // owner_write
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,   // sda_pulled_low, bus_active, wrote, write_index[7:0],
                                     // write_byte[7:0], peek_value[7:0], zero fill
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       owner;
        logic       scl;
        logic       sda;
        logic       scl_drv;
        logic       sda_drv;
        logic [7:0] peek;
    } t_pin_write;

    typedef struct packed {
        logic       sda_low;
        logic       bus_active;
        logic       wrote;
        logic [7:0] wr_index;
        logic [7:0] wr_byte;
        logic [7:0] peek_value;
    } t_slave_result;

    // shadow copy of the slave state
    logic [6:0] slave_addr;
    logic       prev_scl, prev_sda, in_transfer;
    logic [3:0] bit_count;
    logic       addr_done, addr_match, read_req, ptr_done, ack_owed;
    logic [7:0] shift_reg, reg_ptr;
    logic [7:0] reg_mem [i2cs_pkg::STORE_DEPTH];

    t_slave_result owed_results [$];

    task automatic clear_slave();
        slave_addr  = i2cs_pkg::ADDR_RESET;
        prev_scl    = 1'b0;
        prev_sda    = 1'b0;
        in_transfer = 1'b0;
        bit_count   = '0;
        addr_done   = 1'b0;
        addr_match  = 1'b0;
        read_req    = 1'b0;
        ptr_done    = 1'b0;
        ack_owed    = 1'b0;
        shift_reg   = '0;
        reg_ptr     = '0;
        foreach (reg_mem[i]) reg_mem[i] = '0;
    endtask

    // advance the shadow state by one pin write and return the result it gives
    function automatic t_slave_result apply_pin_write(t_pin_write w);
        t_slave_result r;
        logic scl, sda, old_scl, old_sda;
        r       = '0;
        scl     = w.owner ? w.scl : prev_scl;
        sda     = w.owner ? w.sda : prev_sda;
        old_scl = prev_scl;
        old_sda = prev_sda;
        prev_scl = scl;
        prev_sda = sda;

        if (w.scl_drv) begin
            if (old_scl && scl) begin
                // SDA moving under a high SCL: start or stop
                if (w.sda_drv) begin
                    if (old_sda && !sda) begin
                        in_transfer = 1'b1;
                        ack_owed    = 1'b0;
                        bit_count   = '0;
                        addr_done   = 1'b0;
                        addr_match  = 1'b0;
                        read_req    = 1'b0;
                        ptr_done    = 1'b0;
                    end else if (!old_sda && sda) begin
                        in_transfer = 1'b0;
                        bit_count   = '0;
                    end
                end
            end else if (!old_scl && scl) begin
                // SCL rising: shift a bit, or handle the byte once all its data bits are in
                if (in_transfer && (!addr_done || (addr_match && !read_req))) begin
                    if (bit_count >= i2cs_pkg::CNT_DONE) begin
                        ack_owed  = 1'b0;
                        shift_reg = '0;
                        bit_count = '0;
                    end
                    if (bit_count < i2cs_pkg::CNT_ACK)
                        shift_reg = {shift_reg[6:0], sda};
                    if (bit_count == i2cs_pkg::CNT_ACK) begin
                        ack_owed = 1'b1;
                        if (!addr_done) begin
                            addr_done  = 1'b1;
                            addr_match = (shift_reg[7:1] == slave_addr);
                            read_req   = shift_reg[0];
                            if (!addr_match || read_req)
                                ack_owed = 1'b0;
                        end else if (!ptr_done) begin
                            ptr_done = 1'b1;
                            reg_ptr  = shift_reg;
                        end else begin
                            reg_mem[int'(reg_ptr) % i2cs_pkg::STORE_DEPTH] = shift_reg;
                            r.wrote    = 1'b1;
                            r.wr_index = reg_ptr;
                            r.wr_byte  = shift_reg;
                            reg_ptr    = reg_ptr + 8'd1;
                        end
                    end
                    bit_count = bit_count + 4'd1;
                end
            end
        end

        r.sda_low    = (bit_count == i2cs_pkg::CNT_DONE) && ack_owed;
        r.bus_active = in_transfer;
        r.peek_value = reg_mem[int'(w.peek) % i2cs_pkg::STORE_DEPTH];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%02h, want 0x%02h", name, got, want));
    endtask

    // watch both channels at each rising edge
    always @(posedge i_clk) begin : watch
        t_pin_write    w;
        t_slave_result want, got;
        if (!i_rst_n) begin
            clear_slave();
            owed_results.delete();
        end else begin
            if (i_cfg_we)
                slave_addr = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                w.owner   = i_s_tuser;
                w.scl     = i_s_tdata[0];
                w.sda     = i_s_tdata[1];
                w.scl_drv = i_s_tdata[2];
                w.sda_drv = i_s_tdata[3];
                w.peek    = i_s_tdata[11:4];
                owed_results.push_back(apply_pin_write(w));
            end
            if (i_m_tvalid && i_m_tready) begin
                got.sda_low    = i_m_tdata[0];
                got.bus_active = i_m_tdata[1];
                got.wrote      = i_m_tdata[2];
                got.wr_index   = i_m_tdata[10:3];
                got.wr_byte    = i_m_tdata[18:11];
                got.peek_value = i_m_tdata[26:19];
                if (owed_results.size() == 0) begin
                    report_mismatch("result item arrived with nothing expected");
                end else begin
                    want = owed_results.pop_front();
                    check_field("sda_pulled_low", 8'(got.sda_low), 8'(want.sda_low));
                    check_field("bus_active", 8'(got.bus_active), 8'(want.bus_active));
                    check_field("wrote", 8'(got.wrote), 8'(want.wrote));
                    check_field("write_index", got.wr_index, want.wr_index);
                    check_field("write_byte", got.wr_byte, want.wr_byte);
                    check_field("peek_value", got.peek_value, want.peek_value);
                end
            end
        end
        o_pending = owed_results.size();
    end

endmodule

// File: bench/bitbang_i2c_register_slave_tb.sv
module bitbang_i2c_register_slave_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 400;
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [6:0]  i_cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // scl_level, sda_level, scl_driven, sda_driven,
                            // peek_address[7:0], zero fill
    logic        s_tuser;   // owner_write
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // sda_pulled_low, bus_active, wrote, write_index[7:0],
                            // write_byte[7:0], peek_value[7:0], zero fill

    int fail_count;
    int pending;
    int cycles;
    int idle_pct;
    int stall_pct;
    int hold_req;
    int pin_items;
    logic [6:0] cur_addr;
    logic [7:0] hot_index;

    bitbang_i2c_register_slave i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    bitbang_i2c_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : drain
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(1, 100) > stall_pct);
            end
        end
    end

    // offer one pin write; returns at the falling edge after it is taken
    task automatic send_item(input logic owner, input logic scl, input logic sda,
                             input logic scl_drv, input logic sda_drv,
                             input logic [7:0] peek);
        while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= owner;
        s_tdata  <= {4'b0, peek, sda_drv, scl_drv, sda, scl};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (owner)
            pin_items++;
    endtask

    // peek near the bytes just written on about half of the picks, elsewhere at random
    function automatic logic [7:0] pick_peek();
        if ($urandom_range(0, 1) != 0)
            return hot_index - 8'($urandom_range(0, 3));
        return 8'($urandom_range(0, 255));
    endfunction

    // normal pin write with occasional noise or a dropped direction bit
    task automatic send_pins(input logic scl, input logic sda);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
            send_item(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      8'($urandom));
        if (r == 3)
            send_item(1'b1, scl, sda, 1'b0, 1'($urandom), pick_peek());
        else if (r == 4)
            send_item(1'b1, scl, sda, 1'b1, 1'b0, pick_peek());
        else
            send_item(1'b1, scl, sda, 1'b1, 1'b1, pick_peek());
    endtask

    task automatic send_bit(input logic v);
        send_pins(1'b0, v);
        send_pins(1'b1, v);
    endtask

    // eight data bits then the acknowledge clock with SDA released
    task automatic send_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--)
            send_bit(b[i]);
        send_pins(1'b0, 1'b1);
        send_pins(1'b1, 1'b1);
    endtask

    // one transfer, mostly a write: start, address, pointer and data or a cut-off byte, usually a stop
    task automatic send_transfer();
        int kind;
        logic [7:0] addr_byte;
        logic [7:0] ptr;
        send_pins(1'b0, 1'b1);
        send_pins(1'b1, 1'b1);
        send_pins(1'b1, 1'b0);
        kind = $urandom_range(0, 99);
        if (kind < 75)
            addr_byte = {cur_addr, 1'b0};
        else if (kind < 85)
            addr_byte = {cur_addr, 1'b1};
        else
            addr_byte = 8'($urandom_range(0, 255));
        send_byte(addr_byte);
        if ($urandom_range(0, 9) != 0) begin
            ptr = ($urandom_range(0, 3) == 0) ? 8'hFF - 8'($urandom_range(0, 3))
                                              : 8'($urandom_range(0, 255));
            send_byte(ptr);
            hot_index = ptr;
            repeat ($urandom_range(0, 6)) begin
                send_byte(8'($urandom_range(0, 255)));
                hot_index++;
            end
        end else begin
            // cut off inside a byte
            repeat ($urandom_range(1, 7)) send_bit(1'($urandom));
        end
        // most end in a stop, the rest run into a repeated start
        if ($urandom_range(0, 9) < 7) begin
            send_pins(1'b0, 1'b0);
            send_pins(1'b1, 1'b0);
            send_pins(1'b1, 1'b1);
        end
    endtask

    task automatic set_slave_addr(input logic [6:0] a);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= a;
        cur_addr     = a;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // stimulus and verdict
    initial begin : stimulus
        int pressure_done;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        hold_req    = 0;
        pin_items   = 0;
        cur_addr    = 7'h70;
        hot_index   = '0;
        pressure_done = 0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: peek extremes, kept levels, undriven pins, start/stop/restart
        send_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
        send_item(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_item(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 8'hAA);
        send_item(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h55);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00);
        send_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'h01);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h80);
        send_item(1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h7F);
        send_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFE);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
        send_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
        send_item(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
        send_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00);
        send_item(1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
        send_item(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);

        // random phases, each with its own pacing; each phase after the first sets the slave address
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    idle_pct = 0;  stall_pct = 0;
                end
                1: begin
                    set_slave_addr(7'h00);
                    idle_pct = 85; stall_pct = 0;
                end
                2: begin
                    set_slave_addr(7'h7F);
                    idle_pct = 0;  stall_pct = 85;
                end
                default: begin
                    set_slave_addr(7'($urandom_range(1, 126)));
                    idle_pct = 17; stall_pct = 17;
                end
            endcase
            pin_items = 0;
            while (pin_items < PHASE_ITEMS) begin
                if (p == 0 && pressure_done == 0 && pin_items > 100) begin
                    hold_req++;
                    pressure_done = 1;
                end
                send_transfer();
            end
        end

        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: bitbang_i2c_register_slave.f
rtl/i2cs_pkg.sv
rtl/i2cs_front.sv
rtl/i2cs_queue.sv
rtl/i2cs_back.sv
rtl/bitbang_i2c_register_slave.sv
rtl/i2cs_checker.sv
bench/bitbang_i2c_checker.sv
bench/bitbang_i2c_register_slave_tb.sv
